// ===== rtl/core/bls_pkg.sv =====
package bls_pkg;

   localparam int MASK_W   = 8;
   localparam int LEVEL_W  = 4;
   localparam int LEVELS_W = 32;
   localparam int RND_W    = 16;
   localparam int NIBBLE_W = 4;
   localparam int DIR_W    = 3;
   localparam int POS_W    = 3;
   localparam int SUM_W    = 9;
   localparam int RECIP_SH = 12;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int SEEN_W   = 4;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic all_reserved;
      logic no_candidate;
   } bls_flags_type;

endpackage

// ===== rtl/core/buffer_level_output_selector_top.sv =====
// Buffer-level output selector for a network-on-chip router.
// req channel: one item per routing decision, carrying the admissible
// direction mask, the reserved mask, the packed 4-bit free levels and a
// random tie-break value. rsp channel: one item per request, in order,
// with the chosen direction and the all_reserved / no_candidate flags.
// The pipeline runs from req acceptance to rsp_tvalid through a prepare
// stage (masking, level saturation, partial residues of the random value),
// a select stage (greatest level, tie set, residue reduction) and a pick
// stage (tie count and position walk) whose register drives rsp.
// Throughput is one item per cycle; each stage has its own valid bit and
// takes a new item whenever it is empty or its successor moves on, so
// bubbles are squeezed out while the receiver stalls.
// req_tready falls only once all three stages hold an item and rsp_tready
// is low; nothing is dropped or repeated across a stall.
// Reset empties the pipeline; no state survives between items.
module buffer_level_output_selector_top #(
   parameter int NUM_DIRS = 8,
   parameter int MAX_FREE = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // candidate_mask[7:0], reserved_mask[15:8], free_levels[47:16],
   // random_value[63:48]
   input  logic [bls_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // chosen_direction[2:0], all_reserved[3], no_candidate[4], zero fill
   output logic [bls_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import bls_pkg::*;

   logic                s1_valid, s1_ready;
   logic [NUM_DIRS-1:0] s1_cand, s1_free;
   logic [LEVEL_W-1:0]  s1_level [NUM_DIRS];
   logic [SUM_W-1:0]    s1_sum   [NUM_DIRS];

   logic                s2_valid, s2_ready;
   logic [NUM_DIRS-1:0] s2_sel;
   bls_flags_type       s2_flags;
   logic [POS_W-1:0]    s2_res [NUM_DIRS];

   logic [DIR_W-1:0]    s3_direction;
   bls_flags_type       s3_flags;

   bls_prep #(
      .NUM_DIRS (NUM_DIRS),
      .MAX_FREE (MAX_FREE)
   ) u_prep (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .in_candidate_mask (req_tdata[7:0]),
      .in_reserved_mask  (req_tdata[15:8]),
      .in_free_levels    (req_tdata[47:16]),
      .in_random_value   (req_tdata[63:48]),
      .out_valid         (s1_valid),
      .out_ready         (s1_ready),
      .out_cand          (s1_cand),
      .out_free          (s1_free),
      .out_level         (s1_level),
      .out_sum           (s1_sum)
   );

   bls_select #(
      .NUM_DIRS (NUM_DIRS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_cand   (s1_cand),
      .in_free   (s1_free),
      .in_level  (s1_level),
      .in_sum    (s1_sum),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_sel   (s2_sel),
      .out_flags (s2_flags),
      .out_res   (s2_res)
   );

   bls_pick #(
      .NUM_DIRS (NUM_DIRS)
   ) u_pick (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid),
      .in_ready      (s2_ready),
      .in_sel        (s2_sel),
      .in_flags      (s2_flags),
      .in_res        (s2_res),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_direction (s3_direction),
      .out_flags     (s3_flags)
   );

   assign rsp_tdata = {3'b000, s3_flags.no_candidate, s3_flags.all_reserved, s3_direction};

endmodule

// ===== rtl/core/bls_prep.sv =====
module bls_prep #(
   parameter int NUM_DIRS = 8,
   parameter int MAX_FREE = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [bls_pkg::MASK_W-1:0]     in_candidate_mask,
   input  logic [bls_pkg::MASK_W-1:0]     in_reserved_mask,
   input  logic [bls_pkg::LEVELS_W-1:0]   in_free_levels,
   input  logic [bls_pkg::RND_W-1:0]      in_random_value,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [NUM_DIRS-1:0]            out_cand,
   output logic [NUM_DIRS-1:0]            out_free,
   output logic [bls_pkg::LEVEL_W-1:0]    out_level [NUM_DIRS],
   output logic [bls_pkg::SUM_W-1:0]      out_sum   [NUM_DIRS]
);
   import bls_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [NUM_DIRS-1:0] cand_ff, cand_in;
   logic [NUM_DIRS-1:0] free_ff, free_in;
   logic [LEVEL_W-1:0]  level_ff [NUM_DIRS];
   logic [LEVEL_W-1:0]  level_in [NUM_DIRS];
   logic [SUM_W-1:0]    sum_ff   [NUM_DIRS];
   logic [SUM_W-1:0]    sum_in   [NUM_DIRS];
   logic [NIBBLE_W-1:0] nib0, nib1, nib2, nib3;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign nib0 = in_random_value[3:0];
   assign nib1 = in_random_value[7:4];
   assign nib2 = in_random_value[11:8];
   assign nib3 = in_random_value[15:12];

   always_comb begin
      logic [LEVEL_W-1:0] raw;
      for (int d = 0; d < NUM_DIRS; d++) begin
         raw         = in_free_levels[d*LEVEL_W +: LEVEL_W];
         level_in[d] = (raw > LEVEL_W'(MAX_FREE)) ? LEVEL_W'(MAX_FREE) : raw;
         cand_in[d]  = in_candidate_mask[d];
         free_in[d]  = in_candidate_mask[d] & ~in_reserved_mask[d];
      end
   end

   // nibble weights reduced per modulus, sum stays small
   for (genvar m = 1; m <= NUM_DIRS; m++) begin : g_sum
      localparam int W1 = 16 % m;
      localparam int W2 = 256 % m;
      localparam int W3 = 4096 % m;
      assign sum_in[m-1] = SUM_W'(nib0)
                         + SUM_W'(nib1) * SUM_W'(W1)
                         + SUM_W'(nib2) * SUM_W'(W2)
                         + SUM_W'(nib3) * SUM_W'(W3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cand_ff <= cand_in;
         free_ff <= free_in;
         level_ff <= level_in;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cand  = cand_ff;
   assign out_free  = free_ff;
   assign out_level = level_ff;
   assign out_sum   = sum_ff;

endmodule

// ===== rtl/core/bls_select.sv =====
module bls_select #(
   parameter int NUM_DIRS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NUM_DIRS-1:0]           in_cand,
   input  logic [NUM_DIRS-1:0]           in_free,
   input  logic [bls_pkg::LEVEL_W-1:0]   in_level [NUM_DIRS],
   input  logic [bls_pkg::SUM_W-1:0]     in_sum   [NUM_DIRS],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NUM_DIRS-1:0]           out_sel,
   output bls_pkg::bls_flags_type        out_flags,
   output logic [bls_pkg::POS_W-1:0]     out_res [NUM_DIRS]
);
   import bls_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [NUM_DIRS-1:0] sel_ff, sel_in;
   bls_flags_type       flags_ff, flags_in;
   logic [POS_W-1:0]    res_ff [NUM_DIRS];
   logic [POS_W-1:0]    res_in [NUM_DIRS];
   logic [LEVEL_W-1:0]  best;
   logic [NUM_DIRS-1:0] ties;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // greatest level among free directions, zero levels included
   always_comb begin
      best = '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (in_free[d] && in_level[d] > best) begin
            best = in_level[d];
         end
      end
      for (int d = 0; d < NUM_DIRS; d++) begin
         ties[d] = in_free[d] && (in_level[d] == best);
      end
   end

   always_comb begin
      flags_in.no_candidate = (in_cand == '0);
      flags_in.all_reserved = (in_cand != '0) && (in_free == '0);
      sel_in = (in_free == '0) ? in_cand : ties;
   end

   // reciprocal reduction of the weighted sums
   for (genvar m = 1; m <= NUM_DIRS; m++) begin : g_mod
      localparam int RECIP = ((1 << RECIP_SH) + m - 1) / m;
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  quot;
      logic [SUM_W-1:0]  rem;
      assign prod = PROD_W'(in_sum[m-1]) * PROD_W'(RECIP);
      assign quot = prod[RECIP_SH +: SUM_W];
      assign rem  = in_sum[m-1] - quot * SUM_W'(m);
      assign res_in[m-1] = rem[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sel_ff <= sel_in;
         flags_ff <= flags_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sel   = sel_ff;
   assign out_flags = flags_ff;
   assign out_res   = res_ff;

endmodule

// ===== rtl/core/bls_pick.sv =====
module bls_pick #(
   parameter int NUM_DIRS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [NUM_DIRS-1:0]         in_sel,
   input  bls_pkg::bls_flags_type      in_flags,
   input  logic [bls_pkg::POS_W-1:0]   in_res [NUM_DIRS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [bls_pkg::DIR_W-1:0]   out_direction,
   output bls_pkg::bls_flags_type      out_flags
);
   import bls_pkg::*;

   localparam int CNT_W = $clog2(NUM_DIRS + 1);
   localparam int IDX_W = $clog2(NUM_DIRS);

   logic               valid_ff;
   logic               valid_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   bls_flags_type      flags_ff;
   logic [CNT_W-1:0]   cnt;
   logic [CNT_W-1:0]   cnt_m1;
   logic [POS_W-1:0]   pos;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      cnt = '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         cnt = cnt + CNT_W'(in_sel[d]);
      end
      cnt_m1 = cnt - CNT_W'(1);
      pos = (cnt == '0) ? '0 : in_res[cnt_m1[IDX_W-1:0]];
   end

   // walk the set bits in ascending order up to the chosen position
   always_comb begin
      logic [SEEN_W-1:0] seen;
      logic              found;
      seen   = '0;
      found  = 1'b0;
      dir_in = '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (in_sel[d]) begin
            if (!found && seen == SEEN_W'(pos)) begin
               dir_in = DIR_W'(d);
               found  = 1'b1;
            end
            seen = seen + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dir_ff <= dir_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid     = valid_ff;
   assign out_direction = dir_ff;
   assign out_flags     = flags_ff;

endmodule

// ===== tb/buffer_level_output_selector_top_test.sv =====
`timescale 1ns / 1ps

module buffer_level_output_selector_top_test;

   import bls_pkg::*;

   localparam int SEL_DIRS     = 8;
   localparam int SEL_MAX_FREE = 15;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;

   // candidate_mask lowest, random_value highest, as on req_tdata
   typedef struct packed {
      logic [RND_W-1:0]    random_value;
      logic [LEVELS_W-1:0] free_levels;
      logic [MASK_W-1:0]   reserved_mask;
      logic [MASK_W-1:0]   candidate_mask;
   } route_request_type;

   typedef struct packed {
      logic             no_candidate;
      logic             all_reserved;
      logic [DIR_W-1:0] chosen_direction;
   } route_choice_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   route_choice_type expected_choices[$];
   int unsigned      mismatch_count;
   int unsigned      stall_cycles;
   int unsigned      hold_left;
   int unsigned      hold_requests;
   int unsigned      hold_served;
   bit               req_idle_on;
   bit               rsp_idle_on;

   buffer_level_output_selector_top #(
      .NUM_DIRS(SEL_DIRS),
      .MAX_FREE(SEL_MAX_FREE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic route_choice_type predict_choice(route_request_type it);
      logic [MASK_W-1:0] cand;
      logic [MASK_W-1:0] open_dirs;
      logic [MASK_W-1:0] ties;
      int unsigned       best;
      int unsigned       lvl;
      int unsigned       pos;
      int unsigned       seen;
      route_choice_type  c;
      c = '0;
      cand = '0;
      for (int d = 0; d < SEL_DIRS; d++) begin
         cand[d] = it.candidate_mask[d];
      end
      if (cand == '0) begin
         c.no_candidate = 1'b1;
         return c;
      end
      open_dirs = cand & ~it.reserved_mask;
      ties = '0;
      if (open_dirs == '0) begin
         // everything reserved: fall back to all candidates
         ties = cand;
         c.all_reserved = 1'b1;
      end else begin
         best = 0;
         for (int d = 0; d < SEL_DIRS; d++) begin
            if (open_dirs[d]) begin
               lvl = it.free_levels[LEVEL_W*d +: LEVEL_W];
               if (lvl > SEL_MAX_FREE) begin
                  lvl = SEL_MAX_FREE;
               end
               if (lvl > best) begin
                  best = lvl;
                  ties = '0;
                  ties[d] = 1'b1;
               end else if (lvl == best) begin
                  ties[d] = 1'b1;
               end
            end
         end
      end
      pos = it.random_value % $countones(ties);
      seen = 0;
      for (int d = 0; d < SEL_DIRS; d++) begin
         if (ties[d]) begin
            if (seen == pos) begin
               c.chosen_direction = DIR_W'(d);
            end
            seen++;
         end
      end
      return c;
   endfunction

   function automatic route_request_type make_request(logic [MASK_W-1:0] cand,
                                                      logic [MASK_W-1:0] resv,
                                                      logic [LEVELS_W-1:0] levels,
                                                      logic [RND_W-1:0] rnd);
      route_request_type it;
      it.candidate_mask = cand;
      it.reserved_mask  = resv;
      it.free_levels    = levels;
      it.random_value   = rnd;
      return it;
   endfunction

   // mostly well-formed decisions with frequent ties and reservations
   function automatic route_request_type random_request();
      route_request_type it;
      int unsigned       base;
      case ($urandom_range(9))
         0: it.candidate_mask = '0;
         1: it.candidate_mask = '1;
         2: it.candidate_mask = MASK_W'(1) << $urandom_range(MASK_W-1);
         default: it.candidate_mask = MASK_W'($urandom_range(255));
      endcase
      case ($urandom_range(7))
         0: it.reserved_mask = it.candidate_mask;
         1: it.reserved_mask = '0;
         2: it.reserved_mask = '1;
         3: it.reserved_mask = it.candidate_mask | MASK_W'($urandom_range(255));
         default: it.reserved_mask = MASK_W'($urandom_range(255));
      endcase
      case ($urandom_range(3))
         0: it.free_levels = $urandom;
         1: begin
            base = $urandom_range(13);
            for (int d = 0; d < SEL_DIRS; d++) begin
               it.free_levels[LEVEL_W*d +: LEVEL_W] = LEVEL_W'(base + $urandom_range(2));
            end
         end
         2: begin
            base = $urandom_range(15);
            for (int d = 0; d < SEL_DIRS; d++) begin
               it.free_levels[LEVEL_W*d +: LEVEL_W] = LEVEL_W'(base);
            end
         end
         default: begin
            for (int d = 0; d < SEL_DIRS; d++) begin
               it.free_levels[LEVEL_W*d +: LEVEL_W] = $urandom_range(1) ? 4'hf : 4'h0;
            end
         end
      endcase
      case ($urandom_range(5))
         0: it.random_value = RND_W'($urandom_range(7));
         1: it.random_value = '1;
         default: it.random_value = RND_W'($urandom_range(65535));
      endcase
      return it;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   task automatic send_item(route_request_type it);
      if (req_idle_on) begin
         while ($urandom_range(99) < 24) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_choices.insert(expected_choices.size(), predict_choice(it));
   endtask

   task automatic stop_and_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_choices.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_directed();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      // no candidate
      send_item(make_request(8'h00, 8'h00, 32'h0000_0000, 16'h0000));
      send_item(make_request(8'h00, 8'hff, 32'hffff_ffff, 16'hffff));
      // single candidate at both ends
      send_item(make_request(8'h01, 8'h00, 32'h0000_0000, 16'h0000));
      send_item(make_request(8'h80, 8'h00, 32'hffff_ffff, 16'hffff));
      // all levels equal, random value extremes
      send_item(make_request(8'hff, 8'h00, 32'h0000_0000, 16'h0000));
      send_item(make_request(8'hff, 8'h00, 32'h0000_0000, 16'hffff));
      send_item(make_request(8'hff, 8'h00, 32'hffff_ffff, 16'h0005));
      send_item(make_request(8'hff, 8'h00, 32'hffff_ffff, 16'h8000));
      // one clear maximum
      send_item(make_request(8'hff, 8'h00, 32'h0123_4567, 16'h1234));
      send_item(make_request(8'hff, 8'h00, 32'h7654_3210, 16'hfedc));
      // greatest level reserved
      send_item(make_request(8'hff, 8'h80, 32'h7654_3210, 16'h0000));
      // every candidate reserved
      send_item(make_request(8'h0f, 8'hff, 32'h0000_ffff, 16'h0002));
      send_item(make_request(8'hff, 8'hff, 32'h1234_5678, 16'hffff));
      send_item(make_request(8'h24, 8'h24, 32'hffff_ffff, 16'h0001));
      // reserved bits outside the candidates
      send_item(make_request(8'h0f, 8'hf0, 32'h0000_1111, 16'h0003));
      // ties on alternate directions
      send_item(make_request(8'hff, 8'h00, 32'hf0f0_f0f0, 16'h0003));
      send_item(make_request(8'hff, 8'h55, 32'hf0f0_f0f0, 16'h0006));
      // zero-level directions beside open ones at higher levels
      send_item(make_request(8'h03, 8'h01, 32'h0000_00f0, 16'h0000));
      send_item(make_request(8'h70, 8'h00, 32'h0aaa_0000, 16'h8001));
      stop_and_drain();
   endtask

   task automatic test_random_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (300) begin
         send_item(random_request());
      end
      stop_and_drain();
   endtask

   task automatic test_random_idling();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (600) begin
         send_item(random_request());
      end
      stop_and_drain();
   endtask

   task automatic test_receiver_hold_off();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_requests++;
      repeat (80) begin
         send_item(random_request());
      end
      rsp_idle_on = 1'b1;
      hold_requests++;
      repeat (80) begin
         send_item(random_request());
      end
      stop_and_drain();
   endtask

   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (4) begin
         repeat (20) begin
            send_item(random_request());
         end
         stop_and_drain();
      end
   endtask

   initial begin
      rsp_tready  = 1'b0;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_tready <= ($urandom_range(99) >= 24);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      route_choice_type want;
      route_choice_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(route_choice_type)-1:0];
         if (expected_choices.size() == 0) begin
            report_mismatch("unexpected item", 0, rsp_tdata);
         end else begin
            want = expected_choices.pop_front();
            if (got.chosen_direction != want.chosen_direction) begin
               report_mismatch("chosen_direction", want.chosen_direction,
                               got.chosen_direction);
            end
            if (got.all_reserved != want.all_reserved) begin
               report_mismatch("all_reserved", want.all_reserved, got.all_reserved);
            end
            if (got.no_candidate != want.no_candidate) begin
               report_mismatch("no_candidate", want.no_candidate, got.no_candidate);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      hold_requests = 0;
      req_idle_on   = 1'b0;
      rsp_idle_on   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_full_rate();
      test_random_idling();
      test_receiver_hold_off();
      test_sender_pause();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
